>>> src/periodic_task_dispatcher_assert.svh
// ----------------------------------------------------------------------------
// Periodic task dispatcher assertion macros
// Immediate-consequence and next-cycle implication checks, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_DISPATCHER_ASSERT_SVH
`define PERIODIC_TASK_DISPATCHER_ASSERT_SVH

`ifndef SYNTHESIS

// ante |-> cons, sampled on the rising clock edge, off while in reset
`define PTD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("periodic_task_dispatcher: check failed");

// ante |=> cons, sampled on the rising clock edge, off while in reset
`define PTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("periodic_task_dispatcher: check failed");

`else

`define PTD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PTD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// Types, codes and slot search helpers for the periodic task dispatcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptd_pkg;

  // Table geometry and time width
  localparam int NUM_SLOTS = 16;
  localparam int TIME_BITS = 32;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int ID_W      = 4;
  localparam int KIND_W    = 3;
  localparam int MODE_W    = 2;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_COMP_RANGE = 1'b0;  // word index, paddr[2]

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_POLL       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD        = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SET_ENABLE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DELETE     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SET_PERIOD = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SET_PRIO   = 3'd5;

  // Enable modes
  localparam logic [MODE_W-1:0] MODE_DISABLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TOGGLE  = 2'd2;

  // Status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [TIME_BITS-1:0] now;
    logic [ID_W-1:0]      task_id;
    logic [TIME_BITS-1:0] period_ticks;
    logic [MODE_W-1:0]    enable_mode;
    logic                 wants_dt;
    logic                 cancel;
  } item_t;

  typedef struct packed {
    logic                 dispatch;
    logic [ID_W-1:0]      result_id;
    logic [TIME_BITS-1:0] elapsed;
    logic                 pass_elapsed;
    logic                 status;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
  } lookup_t;

  // First live slot at or above 'from'
  function automatic lookup_t find_live(input logic [NUM_SLOTS-1:0] v,
                                        input logic [SLOT_W:0] from);
    lookup_t res;
    res = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (v[i] && ((SLOT_W + 1)'(i) >= from)) begin
        res.found = 1'b1;
        res.idx   = SLOT_W'(i);
      end
    end
    return res;
  endfunction

  // Highest live slot
  function automatic lookup_t find_top(input logic [NUM_SLOTS-1:0] v);
    lookup_t res;
    res = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (v[i]) begin
        res.found = 1'b1;
        res.idx   = SLOT_W'(i);
      end
    end
    return res;
  endfunction

endpackage

>>> src/periodic_task_dispatcher.sv
// ----------------------------------------------------------------------------
// periodic_task_dispatcher
// Round-robin periodic task table with an optional high-priority task.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: an item beat is taken on a clock edge with start high and
//   busy low. Result channel: each result beat sits on out_item for exactly
//   one cycle with out_valid high; the receiver cannot stall it. out_item.last
//   marks the final beat of an item. Configuration: APB port, comp_range at
//   byte address 0, pready tied high; write only while idle.
//   Busy states after the accepting edge (the final result beat, if any, shows
//   up as busy drops): table items pass S_CMD and give one ack beat; a poll
//   with no live task passes S_CMD only; a poll passes S_CMD and S_EXAM1,
//   adding S_EXAM2 with a high-priority task and S_OUT2 when both dispatch.
//   Each examined task costs one read of the period and run-time memories
//   (one read and one write port, read data registered).
//   Reset (synchronous, rst_n low) empties the table, puts the cursor at the
//   end and clears the high-priority task and comp_range. The period and
//   run-time memories are not cleared; add writes an entry before use.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "periodic_task_dispatcher_assert.svh"

module periodic_task_dispatcher (
  input  logic                                clk,
  input  logic                                rst_n,
  // item channel
  input  logic                                start,
  output logic                                busy,
  input  ptd_pkg::item_t                      in_item,
  // result channel
  output logic                                out_valid,
  output ptd_pkg::result_t                    out_item,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ptd_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [ptd_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [ptd_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam int NS = ptd_pkg::NUM_SLOTS;
  localparam int SW = ptd_pkg::SLOT_W;
  localparam int TB = ptd_pkg::TIME_BITS;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMD   = 3'd1;
  localparam logic [2:0] S_EXAM1 = 3'd2;
  localparam logic [2:0] S_EXAM2 = 3'd3;
  localparam logic [2:0] S_OUT2  = 3'd4;

  logic [2:0]               state_r, state_nxt;
  ptd_pkg::item_t           item_r;
  logic [TB-1:0]            comp_range_r;
  logic [NS-1:0]            valid_r, valid_nxt;
  logic [NS-1:0]            enable_r, enable_nxt;
  logic [SW-1:0]            cursor_r, cursor_nxt;
  logic                     cursor_at_end_r, cursor_at_end_nxt;
  logic                     prio_valid_r, prio_valid_nxt;
  logic [SW-1:0]            prio_slot_r, prio_slot_nxt;
  logic [SW-1:0]            exam_slot_r, exam_slot_nxt;
  ptd_pkg::result_t         hold_r, hold_nxt;
  logic                     hold_valid_r, hold_valid_nxt;
  logic                     fwd_r, fwd_nxt;
  logic [TB-1:0]            wb_last_r, wb_last_nxt;
  logic                     out_valid_r, out_valid_nxt;
  ptd_pkg::result_t         out_item_r, out_item_nxt;

  // State memories: period, and {wants_dt, last run}
  logic [TB-1:0]            per_mem [NS];
  logic [TB:0]              run_mem [NS];
  logic [TB-1:0]            per_rd_r;
  logic [TB:0]              run_rd_r;
  logic [SW-1:0]            rd_addr;
  logic [SW-1:0]            wr_addr;
  logic                     per_we;
  logic                     run_we;
  logic [TB-1:0]            per_wdata;
  logic [TB:0]              run_wdata;

  // Decode helpers
  logic                     cfg_wr;
  logic [SW-1:0]            tid;
  logic                     live;
  ptd_pkg::lookup_t         scan_a, scan_b, scan_nxt, top;
  logic [SW:0]              scan_from;
  logic [SW:0]              nxt_from;
  logic [SW-1:0]            poll_slot;
  logic [SW-1:0]            add_id;

  // Examine datapath
  logic [SW-1:0]            ex_slot;
  logic [TB-1:0]            ex_last;
  logic [TB-1:0]            ex_due_at;
  logic [TB-1:0]            ex_late;
  logic                     ex_due;
  logic [TB-1:0]            ex_new_last;
  ptd_pkg::result_t         ex_res;

  // ------------------------------------------------------------------
  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == ptd_pkg::REG_COMP_RANGE) ? comp_range_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_range_r <= '0;
    end else if (cfg_wr && (paddr[2] == ptd_pkg::REG_COMP_RANGE)) begin
      comp_range_r <= pwdata;
    end
  end

  // ------------------------------------------------------------------
  // Memories, read data registered
  always_ff @(posedge clk) begin
    if (per_we) begin
      per_mem[wr_addr] <= per_wdata;
    end
    per_rd_r <= per_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (run_we) begin
      run_mem[wr_addr] <= run_wdata;
    end
    run_rd_r <= run_mem[rd_addr];
  end

  // ------------------------------------------------------------------
  // Slot searches
  assign tid       = SW'(item_r.task_id);
  assign live      = (32'(item_r.task_id) < NS) && valid_r[tid];
  assign scan_from = cursor_at_end_r ? '0 : {1'b0, cursor_r};
  assign scan_a    = ptd_pkg::find_live(valid_r, scan_from);
  assign scan_b    = ptd_pkg::find_live(valid_r, '0);
  assign poll_slot = scan_a.found ? scan_a.idx : scan_b.idx;
  assign nxt_from  = (state_r == S_EXAM1) ? ({1'b0, exam_slot_r} + 1'b1)
                                          : ({1'b0, tid} + 1'b1);
  assign scan_nxt  = ptd_pkg::find_live(valid_r, nxt_from);
  assign top       = ptd_pkg::find_top(valid_r);
  assign add_id    = top.found ? (top.idx + 1'b1) : '0;

  // ------------------------------------------------------------------
  // Examine one task: due check, elapsed and new run time
  assign ex_slot     = (state_r == S_EXAM1) ? exam_slot_r : prio_slot_r;
  assign ex_last     = (state_r == S_EXAM2 && fwd_r) ? wb_last_r : run_rd_r[TB-1:0];
  assign ex_due_at   = ex_last + per_rd_r;
  assign ex_due      = valid_r[ex_slot] && enable_r[ex_slot] && (item_r.now >= ex_due_at);
  assign ex_late     = item_r.now - ex_due_at;
  assign ex_new_last = (ex_late <= comp_range_r) ? ex_due_at : item_r.now;

  always_comb begin
    ex_res              = '0;
    ex_res.dispatch     = 1'b1;
    ex_res.result_id    = ptd_pkg::ID_W'(ex_slot);
    ex_res.elapsed      = item_r.now - ex_last;
    ex_res.pass_elapsed = run_rd_r[TB];
    ex_res.status       = ptd_pkg::STATUS_OK;
    ex_res.last         = 1'b1;
  end

  // ------------------------------------------------------------------
  // Sequencer
  always_comb begin
    state_nxt         = state_r;
    valid_nxt         = valid_r;
    enable_nxt        = enable_r;
    cursor_nxt        = cursor_r;
    cursor_at_end_nxt = cursor_at_end_r;
    prio_valid_nxt    = prio_valid_r;
    prio_slot_nxt     = prio_slot_r;
    exam_slot_nxt     = exam_slot_r;
    hold_nxt          = hold_r;
    hold_valid_nxt    = hold_valid_r;
    fwd_nxt           = fwd_r;
    wb_last_nxt       = wb_last_r;
    out_valid_nxt     = 1'b0;
    out_item_nxt      = out_item_r;
    rd_addr           = poll_slot;
    wr_addr           = ex_slot;
    per_we            = 1'b0;
    run_we            = 1'b0;
    per_wdata         = item_r.period_ticks;
    run_wdata         = {run_rd_r[TB], ex_new_last};

    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_CMD;
        end
      end

      S_CMD: begin
        state_nxt         = S_IDLE;
        out_item_nxt      = '0;
        out_item_nxt.last = 1'b1;
        out_valid_nxt     = 1'b1;
        case (item_r.kind)
          ptd_pkg::KIND_POLL: begin
            out_valid_nxt = 1'b0;
            if (scan_b.found) begin
              rd_addr       = poll_slot;
              exam_slot_nxt = poll_slot;
              state_nxt     = S_EXAM1;
            end
          end
          ptd_pkg::KIND_ADD: begin
            if (valid_r[NS-1]) begin
              out_item_nxt.status = ptd_pkg::STATUS_FULL;
            end else begin
              wr_addr                = add_id;
              per_we                 = 1'b1;
              run_we                 = 1'b1;
              per_wdata              = item_r.period_ticks;
              run_wdata              = {item_r.wants_dt, item_r.now - item_r.period_ticks};
              valid_nxt[add_id]      = 1'b1;
              enable_nxt[add_id]     = (item_r.enable_mode != ptd_pkg::MODE_DISABLE);
              out_item_nxt.result_id = ptd_pkg::ID_W'(add_id);
            end
          end
          ptd_pkg::KIND_SET_ENABLE: begin
            if (live) begin
              if (item_r.enable_mode == ptd_pkg::MODE_TOGGLE) begin
                enable_nxt[tid] = !enable_r[tid];
              end else begin
                enable_nxt[tid] = (item_r.enable_mode != ptd_pkg::MODE_DISABLE);
              end
            end
          end
          ptd_pkg::KIND_DELETE: begin
            if (live) begin
              // cursor on the deleted slot moves on
              if (!cursor_at_end_r && cursor_r == tid) begin
                if (scan_nxt.found) begin
                  cursor_nxt = scan_nxt.idx;
                end else begin
                  cursor_at_end_nxt = 1'b1;
                end
              end
              if (prio_valid_r && prio_slot_r == tid) begin
                prio_valid_nxt = 1'b0;
              end
              valid_nxt[tid] = 1'b0;
            end
          end
          ptd_pkg::KIND_SET_PERIOD: begin
            if (live) begin
              wr_addr   = tid;
              per_we    = 1'b1;
              per_wdata = (item_r.period_ticks == '0) ? TB'(1) : item_r.period_ticks;
            end
          end
          ptd_pkg::KIND_SET_PRIO: begin
            prio_valid_nxt = !item_r.cancel && live;
            if (!item_r.cancel && live) begin
              prio_slot_nxt = tid;
            end
          end
          default: begin
            out_valid_nxt = 1'b0;
          end
        endcase
      end

      S_EXAM1: begin
        // advance the round-robin cursor
        if (scan_nxt.found) begin
          cursor_nxt        = scan_nxt.idx;
          cursor_at_end_nxt = 1'b0;
        end else begin
          cursor_at_end_nxt = 1'b1;
        end
        wr_addr = exam_slot_r;
        run_we  = ex_due;
        if (prio_valid_r) begin
          // second read; forward the run time just written to the same slot
          rd_addr        = prio_slot_r;
          hold_nxt       = ex_res;
          hold_valid_nxt = ex_due;
          fwd_nxt        = ex_due && (prio_slot_r == exam_slot_r);
          wb_last_nxt    = ex_new_last;
          state_nxt      = S_EXAM2;
        end else begin
          out_valid_nxt = ex_due;
          out_item_nxt  = ex_res;
          state_nxt     = S_IDLE;
        end
      end

      S_EXAM2: begin
        wr_addr   = prio_slot_r;
        run_we    = ex_due;
        state_nxt = S_IDLE;
        if (hold_valid_r) begin
          out_valid_nxt     = 1'b1;
          out_item_nxt      = hold_r;
          out_item_nxt.last = !ex_due;
          if (ex_due) begin
            hold_nxt  = ex_res;
            state_nxt = S_OUT2;
          end
        end else begin
          out_valid_nxt = ex_due;
          out_item_nxt  = ex_res;
        end
      end

      S_OUT2: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = hold_r;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      valid_r         <= '0;
      enable_r        <= '0;
      cursor_r        <= '0;
      cursor_at_end_r <= 1'b1;
      prio_valid_r    <= 1'b0;
      prio_slot_r     <= '0;
      hold_valid_r    <= 1'b0;
      fwd_r           <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      valid_r         <= valid_nxt;
      enable_r        <= enable_nxt;
      cursor_r        <= cursor_nxt;
      cursor_at_end_r <= cursor_at_end_nxt;
      prio_valid_r    <= prio_valid_nxt;
      prio_slot_r     <= prio_slot_nxt;
      hold_valid_r    <= hold_valid_nxt;
      fwd_r           <= fwd_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      item_r <= in_item;
    end
    exam_slot_r <= exam_slot_nxt;
    hold_r      <= hold_nxt;
    wb_last_r   <= wb_last_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // ------------------------------------------------------------------
  // Checks
  `PTD_ASSERT_NEXT(a_pair_follows, clk, rst_n, out_valid_r && !out_item_r.last, out_valid_r && out_item_r.last)
  `PTD_ASSERT_NOW(a_prio_live, clk, rst_n, prio_valid_r, valid_r[prio_slot_r])
  `PTD_ASSERT_NOW(a_cursor_live, clk, rst_n, !cursor_at_end_r, valid_r[cursor_r])
  `PTD_ASSERT_NOW(a_full_ack, clk, rst_n, out_valid_r && out_item_r.status, !out_item_r.dispatch && out_item_r.last)

endmodule
